### rtl/core/dmf_pkg.sv
// Shared types and constants for the Dinic max-flow engine.
package dmf_pkg;

    localparam int FLOW_W = 26;
    localparam int CAP_IN_W = 16;
    localparam int VTX_IN_W = 6;
    localparam int VCOUNT_W = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [FLOW_W-1:0] FLOW_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SINK = 2'd2;

    typedef enum logic [1:0] {
        RES_OK = 2'd0,
        RES_BAD_VERTEX = 2'd1,
        RES_ARCS_FULL = 2'd2
    } dmf_result_t;

    typedef enum logic [5:0] {
        S_IDLE,
        S_DECODE,
        S_ADD0,
        S_ADD1,
        S_ADD2,
        S_ADD3,
        S_BFS_CLR,
        S_BFS_INIT,
        S_BFS_POP,
        S_BFS_U,
        S_BFS_FIRST,
        S_BFS_ARC,
        S_BFS_H,
        S_BFS_CHK,
        S_BFS_DONE,
        S_CA_RD,
        S_CA_WR,
        S_PUSH_START,
        S_PV,
        S_PV_A,
        S_SCAN,
        S_SCAN_H,
        S_SCAN_CHK,
        S_ADV,
        S_RET1,
        S_RET2,
        S_RET3,
        S_AUG_RD,
        S_AUG_A,
        S_AUG_R,
        S_AP_RD,
        S_AP_A,
        S_AP_F,
        S_AP_G,
        S_TOTAL,
        S_FIN
    } dmf_state_t;

    typedef struct packed {
        dmf_state_t op;
        logic       accept;
    } dmf_cmd_t;

    typedef struct packed {
        logic is_add;
        logic bad_vertex;
        logic arcs_full;
        logic same_st;
        logic clr_last;
        logic q_done;
        logic t_reached;
        logic a_none;
        logic at_sink;
        logic scan_ok;
        logic can_adv;
        logic depth_zero;
        logic more;
        logic out_free;
    } dmf_status_t;

endpackage

### rtl/core/dmf_ctrl.sv
// Sequencer for edge loads, level-graph build and blocking-flow pushes.
module dmf_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  dmf_pkg::dmf_status_t st,
    output dmf_pkg::dmf_cmd_t    cmd
);

    dmf_pkg::dmf_state_t state_reg;
    dmf_pkg::dmf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dmf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dmf_pkg::S_IDLE:
            begin
                if (s_tvalid && st.out_free)
                begin
                    state_next = dmf_pkg::S_DECODE;
                end
            end
            dmf_pkg::S_DECODE:
            begin
                priority if (st.bad_vertex || (st.is_add && st.arcs_full)
                             || (!st.is_add && st.same_st))
                begin
                    state_next = dmf_pkg::S_FIN;
                end
                else if (st.is_add)
                begin
                    state_next = dmf_pkg::S_ADD0;
                end
                else
                begin
                    state_next = dmf_pkg::S_BFS_CLR;
                end
            end
            dmf_pkg::S_ADD0: state_next = dmf_pkg::S_ADD1;
            dmf_pkg::S_ADD1: state_next = dmf_pkg::S_ADD2;
            dmf_pkg::S_ADD2: state_next = dmf_pkg::S_ADD3;
            dmf_pkg::S_ADD3: state_next = dmf_pkg::S_FIN;
            dmf_pkg::S_BFS_CLR:
            begin
                if (st.clr_last)
                begin
                    state_next = dmf_pkg::S_BFS_INIT;
                end
            end
            dmf_pkg::S_BFS_INIT: state_next = dmf_pkg::S_BFS_POP;
            dmf_pkg::S_BFS_POP:
            begin
                state_next = st.q_done ? dmf_pkg::S_BFS_DONE : dmf_pkg::S_BFS_U;
            end
            dmf_pkg::S_BFS_U: state_next = dmf_pkg::S_BFS_FIRST;
            dmf_pkg::S_BFS_FIRST: state_next = dmf_pkg::S_BFS_ARC;
            dmf_pkg::S_BFS_ARC:
            begin
                state_next = st.a_none ? dmf_pkg::S_BFS_POP : dmf_pkg::S_BFS_H;
            end
            dmf_pkg::S_BFS_H: state_next = dmf_pkg::S_BFS_CHK;
            dmf_pkg::S_BFS_CHK: state_next = dmf_pkg::S_BFS_ARC;
            dmf_pkg::S_BFS_DONE:
            begin
                state_next = st.t_reached ? dmf_pkg::S_CA_RD : dmf_pkg::S_FIN;
            end
            dmf_pkg::S_CA_RD: state_next = dmf_pkg::S_CA_WR;
            dmf_pkg::S_CA_WR:
            begin
                state_next = st.clr_last ? dmf_pkg::S_PUSH_START : dmf_pkg::S_CA_RD;
            end
            dmf_pkg::S_PUSH_START: state_next = dmf_pkg::S_PV;
            dmf_pkg::S_PV:
            begin
                state_next = st.at_sink ? dmf_pkg::S_AUG_RD : dmf_pkg::S_PV_A;
            end
            dmf_pkg::S_PV_A: state_next = dmf_pkg::S_SCAN;
            dmf_pkg::S_SCAN:
            begin
                state_next = st.a_none ? dmf_pkg::S_ADV : dmf_pkg::S_SCAN_H;
            end
            dmf_pkg::S_SCAN_H: state_next = dmf_pkg::S_SCAN_CHK;
            dmf_pkg::S_SCAN_CHK:
            begin
                state_next = st.scan_ok ? dmf_pkg::S_ADV : dmf_pkg::S_SCAN;
            end
            dmf_pkg::S_ADV:
            begin
                priority if (st.can_adv)
                begin
                    state_next = dmf_pkg::S_PV;
                end
                else if (st.depth_zero)
                begin
                    state_next = dmf_pkg::S_BFS_CLR;
                end
                else
                begin
                    state_next = dmf_pkg::S_RET1;
                end
            end
            dmf_pkg::S_RET1: state_next = dmf_pkg::S_RET2;
            dmf_pkg::S_RET2: state_next = dmf_pkg::S_RET3;
            dmf_pkg::S_RET3: state_next = dmf_pkg::S_PV;
            dmf_pkg::S_AUG_RD: state_next = dmf_pkg::S_AUG_A;
            dmf_pkg::S_AUG_A: state_next = dmf_pkg::S_AUG_R;
            dmf_pkg::S_AUG_R:
            begin
                state_next = st.more ? dmf_pkg::S_AUG_RD : dmf_pkg::S_AP_RD;
            end
            dmf_pkg::S_AP_RD: state_next = dmf_pkg::S_AP_A;
            dmf_pkg::S_AP_A: state_next = dmf_pkg::S_AP_F;
            dmf_pkg::S_AP_F: state_next = dmf_pkg::S_AP_G;
            dmf_pkg::S_AP_G:
            begin
                state_next = st.more ? dmf_pkg::S_AP_RD : dmf_pkg::S_TOTAL;
            end
            dmf_pkg::S_TOTAL: state_next = dmf_pkg::S_PUSH_START;
            dmf_pkg::S_FIN:
            begin
                if (st.out_free)
                begin
                    state_next = dmf_pkg::S_IDLE;
                end
            end
            default: state_next = dmf_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = (state_reg == dmf_pkg::S_IDLE) && st.out_free;
        cmd.op = state_reg;
        cmd.accept = s_tvalid && s_tready;
    end

endmodule

### rtl/core/dmf_datapath.sv
// Arc store, per-vertex tables, search registers and result register.
module dmf_datapath
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_ARCS = 2048,
    parameter int CAP_BITS = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  dmf_pkg::dmf_cmd_t                cmd,
    output dmf_pkg::dmf_status_t             st,
    input  logic                             in_kind,
    input  logic [dmf_pkg::VTX_IN_W-1:0]     in_from,
    input  logic [dmf_pkg::VTX_IN_W-1:0]     in_to,
    input  logic [dmf_pkg::CAP_IN_W-1:0]     in_cap,
    input  logic                             cfg_we,
    input  logic [dmf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dmf_pkg::VCOUNT_W-1:0]     cfg_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       out_status,
    output logic [dmf_pkg::FLOW_W-1:0]       out_flow
);

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int DW = $clog2(MAX_VERTICES + 1);
    localparam int LW = $clog2(MAX_VERTICES + 2);
    localparam int AW = (MAX_ARCS > 1) ? $clog2(MAX_ARCS) : 1;
    localparam int PW = AW + 1;
    localparam int CW = $clog2(MAX_ARCS + 1);
    localparam int FW = CAP_BITS + 1;
    localparam int RW = CAP_BITS + 2;
    localparam int SW = 34;
    localparam logic [PW-1:0] NO_ARC = PW'(MAX_ARCS);

    logic [VW-1:0]       head_mem [MAX_ARCS];
    logic [CAP_BITS-1:0] cap_mem [MAX_ARCS];
    logic [FW-1:0]       flow_mem [MAX_ARCS];
    logic [AW-1:0]       next_mem [MAX_ARCS];
    logic [AW-1:0]       first_mem [MAX_VERTICES];
    logic [AW-1:0]       last_mem [MAX_VERTICES];
    logic [LW-1:0]       lev_mem [MAX_VERTICES];
    logic [PW-1:0]       cur_mem [MAX_VERTICES];
    logic [VW-1:0]       q_mem [MAX_VERTICES];
    logic [AW-1:0]       stk_mem [MAX_VERTICES];

    logic [VW-1:0]       head_rd;
    logic [CAP_BITS-1:0] cap_rd;
    logic [FW-1:0]       flow_rd;
    logic [AW-1:0]       next_rd;
    logic [AW-1:0]       first_rd;
    logic                fv_rd;
    logic [AW-1:0]       last_rd;
    logic [LW-1:0]       lev_rd;
    logic [PW-1:0]       cur_rd;
    logic [VW-1:0]       q_rd;
    logic [AW-1:0]       stk_rd;

    logic                arc_we, flow_we, next_we, first_we, last_we;
    logic                lev_we, cur_we, q_we, stk_we;
    logic [AW-1:0]       arc_wa, flow_wa, next_wa;
    logic [VW-1:0]       head_wd;
    logic [CAP_BITS-1:0] cap_wd;
    logic [FW-1:0]       flow_wd;
    logic [AW-1:0]       next_wd, first_wd, last_wd;
    logic [VW-1:0]       first_wa, last_wa, lev_wa, cur_wa, q_wa, stk_wa;
    logic [LW-1:0]       lev_wd;
    logic [PW-1:0]       cur_wd;
    logic [VW-1:0]       q_wd;
    logic [AW-1:0]       stk_wd;
    logic [AW-1:0]       head_ra, cap_ra, flow_ra, next_ra;
    logic [VW-1:0]       first_ra, last_ra, lev_ra, cur_ra, q_ra, stk_ra;

    logic [dmf_pkg::VCOUNT_W-1:0] vcount_reg;
    logic [dmf_pkg::VTX_IN_W-1:0] src_reg;
    logic [dmf_pkg::VTX_IN_W-1:0] snk_reg;
    logic [CW-1:0]                arc_count_reg;
    logic [MAX_VERTICES-1:0]      fv_reg;
    logic                         out_valid_reg;

    logic                         kind_reg;
    logic [dmf_pkg::VTX_IN_W-1:0] from_reg;
    logic [dmf_pkg::VTX_IN_W-1:0] to_reg;
    logic [dmf_pkg::CAP_IN_W-1:0] cap_reg;
    logic [1:0]                   res_status_reg;
    logic [dmf_pkg::FLOW_W-1:0]   total_reg;
    logic [1:0]                   out_status_reg;
    logic [dmf_pkg::FLOW_W-1:0]   out_flow_reg;
    logic [VW-1:0]                idx_reg;
    logic [DW-1:0]                qh_reg, qt_reg, depth_reg;
    logic                         treach_reg;
    logic [VW-1:0]                v_reg, h_reg;
    logic [LW-1:0]                lev_reg;
    logic [PW-1:0]                a_reg, nexta_reg;
    logic [AW-1:0]                nhold_reg;
    logic                         respos_reg;
    logic [CAP_BITS-1:0]          amt_reg;

    logic [AW-1:0]       a_idx, a0, a1;
    logic [VW-1:0]       fidx, tidx, sidx, kidx;
    logic [RW-1:0]       res_full;
    logic                res_pos;
    logic [CAP_BITS-1:0] res_val;
    logic [PW-1:0]       nexta;
    logic                bfs_take;
    logic [SW-1:0]       sum;
    logic                out_free;

    assign a_idx = a_reg[AW-1:0];
    assign a0 = arc_count_reg[AW-1:0];
    assign a1 = a0 ^ AW'(1);
    assign fidx = VW'(from_reg);
    assign tidx = VW'(to_reg);
    assign sidx = VW'(src_reg);
    assign kidx = VW'(snk_reg);
    assign res_full = RW'({2'b00, cap_rd}) - RW'({flow_rd[FW-1], flow_rd});
    assign res_pos = !res_full[RW-1] && (res_full != '0);
    assign res_val = res_full[CAP_BITS-1:0];
    assign nexta = (a_idx == last_rd) ? NO_ARC : {1'b0, next_rd};
    assign bfs_take = (lev_rd == '0) && respos_reg && (32'(qt_reg) < 32'(MAX_VERTICES));
    assign sum = SW'(total_reg) + SW'(amt_reg);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        st.is_add = !kind_reg;
        st.bad_vertex = kind_reg
            ? (32'(src_reg) >= 32'(vcount_reg) || 32'(src_reg) >= 32'(MAX_VERTICES)
               || 32'(snk_reg) >= 32'(vcount_reg) || 32'(snk_reg) >= 32'(MAX_VERTICES))
            : (32'(from_reg) >= 32'(vcount_reg) || 32'(from_reg) >= 32'(MAX_VERTICES)
               || 32'(to_reg) >= 32'(vcount_reg) || 32'(to_reg) >= 32'(MAX_VERTICES));
        st.arcs_full = (32'(arc_count_reg) + 32'd2) > 32'(MAX_ARCS);
        st.same_st = (src_reg == snk_reg);
        st.clr_last = (idx_reg == VW'(MAX_VERTICES - 1));
        st.q_done = !(qh_reg < qt_reg) || treach_reg;
        st.t_reached = treach_reg;
        st.a_none = (a_reg >= NO_ARC);
        st.at_sink = (v_reg == kidx);
        st.scan_ok = (LW'(lev_reg + 1'b1) == lev_rd) && respos_reg;
        st.can_adv = (a_reg < NO_ARC) && (32'(depth_reg) < 32'(MAX_VERTICES));
        st.depth_zero = (depth_reg == '0);
        st.more = (32'(idx_reg) + 32'd1) < 32'(depth_reg);
        st.out_free = out_free;
    end

    always_comb
    begin
        arc_we = 1'b0;
        flow_we = 1'b0;
        next_we = 1'b0;
        first_we = 1'b0;
        last_we = 1'b0;
        lev_we = 1'b0;
        cur_we = 1'b0;
        q_we = 1'b0;
        stk_we = 1'b0;
        arc_wa = a0;
        flow_wa = a_idx;
        next_wa = last_rd;
        head_wd = tidx;
        cap_wd = CAP_BITS'(cap_reg);
        flow_wd = '0;
        next_wd = a0;
        first_wa = fidx;
        first_wd = a0;
        last_wa = fidx;
        last_wd = a0;
        lev_wa = idx_reg;
        lev_wd = '0;
        cur_wa = v_reg;
        cur_wd = a_reg;
        q_wa = VW'(qt_reg);
        q_wd = h_reg;
        stk_wa = VW'(depth_reg);
        stk_wd = a_idx;
        head_ra = a_idx;
        cap_ra = a_idx;
        flow_ra = a_idx;
        next_ra = a_idx;
        first_ra = idx_reg;
        last_ra = v_reg;
        lev_ra = v_reg;
        cur_ra = v_reg;
        q_ra = VW'(qh_reg);
        stk_ra = idx_reg;
        unique case (cmd.op)
            dmf_pkg::S_ADD0:
            begin
                arc_we = 1'b1;
                flow_we = 1'b1;
                flow_wa = a0;
                last_ra = fidx;
            end
            dmf_pkg::S_ADD1:
            begin
                arc_we = 1'b1;
                arc_wa = a1;
                head_wd = fidx;
                cap_wd = '0;
                flow_we = 1'b1;
                flow_wa = a1;
                next_we = fv_reg[fidx];
                first_we = !fv_reg[fidx];
                last_we = 1'b1;
            end
            dmf_pkg::S_ADD2:
            begin
                last_ra = tidx;
            end
            dmf_pkg::S_ADD3:
            begin
                next_wd = a1;
                next_we = fv_reg[tidx];
                first_we = !fv_reg[tidx];
                first_wa = tidx;
                first_wd = a1;
                last_we = 1'b1;
                last_wa = tidx;
                last_wd = a1;
            end
            dmf_pkg::S_BFS_CLR:
            begin
                lev_we = 1'b1;
            end
            dmf_pkg::S_BFS_INIT:
            begin
                lev_we = 1'b1;
                lev_wa = sidx;
                lev_wd = LW'(1);
                q_we = 1'b1;
                q_wa = '0;
                q_wd = sidx;
            end
            dmf_pkg::S_BFS_U:
            begin
                first_ra = q_rd;
                lev_ra = q_rd;
            end
            dmf_pkg::S_BFS_H, dmf_pkg::S_SCAN_H:
            begin
                lev_ra = head_rd;
            end
            dmf_pkg::S_BFS_CHK:
            begin
                lev_we = bfs_take;
                lev_wa = h_reg;
                lev_wd = LW'(lev_reg + 1'b1);
                q_we = bfs_take;
            end
            dmf_pkg::S_CA_WR:
            begin
                cur_we = 1'b1;
                cur_wa = idx_reg;
                cur_wd = fv_rd ? {1'b0, first_rd} : NO_ARC;
            end
            dmf_pkg::S_ADV:
            begin
                cur_we = 1'b1;
                stk_we = st.can_adv;
                stk_ra = VW'(depth_reg - 1'b1);
            end
            dmf_pkg::S_RET1:
            begin
                head_ra = stk_rd ^ AW'(1);
                next_ra = stk_rd;
            end
            dmf_pkg::S_RET2:
            begin
                last_ra = head_rd;
            end
            dmf_pkg::S_RET3:
            begin
                cur_we = 1'b1;
                cur_wd = (a_idx == last_rd) ? NO_ARC : {1'b0, nhold_reg};
            end
            dmf_pkg::S_AUG_A:
            begin
                cap_ra = stk_rd;
                flow_ra = stk_rd;
            end
            dmf_pkg::S_AP_A:
            begin
                flow_ra = stk_rd;
            end
            dmf_pkg::S_AP_F:
            begin
                flow_we = 1'b1;
                flow_wd = flow_rd + FW'(amt_reg);
                flow_ra = a_idx ^ AW'(1);
            end
            dmf_pkg::S_AP_G:
            begin
                flow_we = 1'b1;
                flow_wa = a_idx ^ AW'(1);
                flow_wd = flow_rd - FW'(amt_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (arc_we)
        begin
            head_mem[arc_wa] <= head_wd;
            cap_mem[arc_wa] <= cap_wd;
        end
        if (flow_we)
        begin
            flow_mem[flow_wa] <= flow_wd;
        end
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (first_we)
        begin
            first_mem[first_wa] <= first_wd;
        end
        if (last_we)
        begin
            last_mem[last_wa] <= last_wd;
        end
        if (lev_we)
        begin
            lev_mem[lev_wa] <= lev_wd;
        end
        if (cur_we)
        begin
            cur_mem[cur_wa] <= cur_wd;
        end
        if (q_we)
        begin
            q_mem[q_wa] <= q_wd;
        end
        if (stk_we)
        begin
            stk_mem[stk_wa] <= stk_wd;
        end
        head_rd <= head_mem[head_ra];
        cap_rd <= cap_mem[cap_ra];
        flow_rd <= flow_mem[flow_ra];
        next_rd <= next_mem[next_ra];
        first_rd <= first_mem[first_ra];
        fv_rd <= fv_reg[first_ra];
        last_rd <= last_mem[last_ra];
        lev_rd <= lev_mem[lev_ra];
        cur_rd <= cur_mem[cur_ra];
        q_rd <= q_mem[q_ra];
        stk_rd <= stk_mem[stk_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= dmf_pkg::VCOUNT_W'(64);
            src_reg <= '0;
            snk_reg <= dmf_pkg::VTX_IN_W'(1);
            arc_count_reg <= '0;
            fv_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    dmf_pkg::CFG_VERTEX_COUNT: vcount_reg <= cfg_data;
                    dmf_pkg::CFG_SOURCE: src_reg <= cfg_data[dmf_pkg::VTX_IN_W-1:0];
                    dmf_pkg::CFG_SINK: snk_reg <= cfg_data[dmf_pkg::VTX_IN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.op == dmf_pkg::S_ADD1)
            begin
                fv_reg[fidx] <= 1'b1;
            end
            if (cmd.op == dmf_pkg::S_ADD3)
            begin
                fv_reg[tidx] <= 1'b1;
                arc_count_reg <= arc_count_reg + CW'(2);
            end
            if (cmd.op == dmf_pkg::S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg <= in_kind;
            from_reg <= in_from;
            to_reg <= in_to;
            cap_reg <= in_cap;
        end
        unique case (cmd.op)
            dmf_pkg::S_DECODE:
            begin
                total_reg <= '0;
                idx_reg <= '0;
                if (st.bad_vertex)
                begin
                    res_status_reg <= dmf_pkg::RES_BAD_VERTEX;
                end
                else if (st.is_add && st.arcs_full)
                begin
                    res_status_reg <= dmf_pkg::RES_ARCS_FULL;
                end
                else
                begin
                    res_status_reg <= dmf_pkg::RES_OK;
                end
            end
            dmf_pkg::S_BFS_CLR:
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            dmf_pkg::S_BFS_INIT:
            begin
                qh_reg <= '0;
                qt_reg <= DW'(1);
                treach_reg <= 1'b0;
            end
            dmf_pkg::S_BFS_POP:
            begin
                qh_reg <= qh_reg + 1'b1;
            end
            dmf_pkg::S_BFS_U:
            begin
                v_reg <= q_rd;
            end
            dmf_pkg::S_BFS_FIRST:
            begin
                a_reg <= fv_rd ? {1'b0, first_rd} : NO_ARC;
                lev_reg <= lev_rd;
            end
            dmf_pkg::S_BFS_H, dmf_pkg::S_SCAN_H:
            begin
                h_reg <= head_rd;
                respos_reg <= res_pos;
                nexta_reg <= nexta;
            end
            dmf_pkg::S_BFS_CHK:
            begin
                a_reg <= nexta_reg;
                if (bfs_take)
                begin
                    qt_reg <= qt_reg + 1'b1;
                    if (h_reg == kidx)
                    begin
                        treach_reg <= 1'b1;
                    end
                end
            end
            dmf_pkg::S_BFS_DONE:
            begin
                idx_reg <= '0;
            end
            dmf_pkg::S_CA_WR:
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            dmf_pkg::S_PUSH_START:
            begin
                v_reg <= sidx;
                depth_reg <= '0;
            end
            dmf_pkg::S_PV:
            begin
                idx_reg <= '0;
                amt_reg <= '1;
            end
            dmf_pkg::S_PV_A:
            begin
                a_reg <= cur_rd;
                lev_reg <= lev_rd;
            end
            dmf_pkg::S_SCAN_CHK:
            begin
                if (!st.scan_ok)
                begin
                    a_reg <= nexta_reg;
                end
            end
            dmf_pkg::S_ADV:
            begin
                idx_reg <= '0;
                if (st.can_adv)
                begin
                    depth_reg <= depth_reg + 1'b1;
                    v_reg <= h_reg;
                end
                else if (!st.depth_zero)
                begin
                    depth_reg <= depth_reg - 1'b1;
                end
            end
            dmf_pkg::S_RET1:
            begin
                a_reg <= {1'b0, stk_rd};
            end
            dmf_pkg::S_RET2:
            begin
                v_reg <= head_rd;
                nhold_reg <= next_rd;
            end
            dmf_pkg::S_AUG_A, dmf_pkg::S_AP_A:
            begin
                a_reg <= {1'b0, stk_rd};
            end
            dmf_pkg::S_AUG_R:
            begin
                if (res_val < amt_reg)
                begin
                    amt_reg <= res_val;
                end
                idx_reg <= st.more ? idx_reg + 1'b1 : '0;
            end
            dmf_pkg::S_AP_G:
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            dmf_pkg::S_TOTAL:
            begin
                total_reg <= (sum > SW'(dmf_pkg::FLOW_MAX))
                    ? dmf_pkg::FLOW_MAX : sum[dmf_pkg::FLOW_W-1:0];
            end
            dmf_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    out_status_reg <= res_status_reg;
                    out_flow_reg <= total_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_flow = out_flow_reg;

endmodule

### rtl/core/dinic_max_flow_top.sv
// Dinic max-flow engine: streaming edge loads and flow requests, one result beat each.
// An edge add stores the arc and its reverse arc. A flow request runs phases until
// the sink is unreachable; each phase clears the level table, runs a breadth-first
// pass that dequeues vertices and visits their arcs, loads the current-arc table,
// then searches by scanning arcs, advancing and retreating, and augments along each
// path found, first finding its smallest residual and then updating the flow on each
// path arc. Each arc and vertex memory has one write port and one registered read port.
// A new beat is taken once the previous result slot is free; flows stay stored across
// requests.
module dinic_max_flow_top
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_ARCS = 2048,
    parameter int CAP_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // from_vertex[5:0], to_vertex[11:6], capacity[27:12]
    input  logic [0:0]  s_tuser,   // kind[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // status[1:0], max_flow[27:2]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    dmf_pkg::dmf_cmd_t    cmd;
    dmf_pkg::dmf_status_t st;
    logic [1:0]           out_status;
    logic [dmf_pkg::FLOW_W-1:0] out_flow;

    dmf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    dmf_datapath
    #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_ARCS     (MAX_ARCS),
        .CAP_BITS     (CAP_BITS)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .in_kind    (s_tuser[0]),
        .in_from    (s_tdata[5:0]),
        .in_to      (s_tdata[11:6]),
        .in_cap     (s_tdata[27:12]),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_flow   (out_flow)
    );

    assign m_tdata = {4'b0000, out_flow, out_status};

endmodule
